FILE: src/qosm_pkg.sv
// shared types and constants of the queue occupancy statistics monitor
package qosm_pkg;

    localparam int unsigned AVG_W      = 64;
    localparam int unsigned CNT_W      = 32;
    localparam int unsigned SENT_W     = 48;
    localparam int unsigned DISC_W     = 16;
    localparam int unsigned PERIOD_W   = 32;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CHUNK_W    = 16;
    localparam int unsigned DIV_STEPS  = 64;
    localparam int unsigned DIV_CNT_W  = 6;

    localparam logic OP_REPORT = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_EVERY_EVENT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_DSTART,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic accept;
        logic mul_step;
        logic acc;
        logic div_start;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic sample_pend;
        logic use_div;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

FILE: src/qosm_in_if.sv
// input channel: queue reports and sample requests
interface qosm_in_if #(
    parameter int unsigned SIZE_BITS = 24,
    parameter int unsigned TIME_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic                 opcode;
    logic [TIME_BITS-1:0] timestamp;
    logic [SIZE_BITS-1:0] queue_size;
    logic [15:0]          discards;

    modport source (output valid, output opcode, output timestamp, output queue_size,
                    output discards, input ready);
    modport sink   (input valid, input opcode, input timestamp, input queue_size,
                    input discards, output ready);
endinterface

FILE: src/qosm_out_if.sv
// output channel: statistics samples
interface qosm_out_if #(
    parameter int unsigned SIZE_BITS = 24,
    parameter int unsigned TIME_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic [SIZE_BITS-1:0] max_size;
    logic [SIZE_BITS-1:0] min_size;
    logic [63:0]          avg_size;
    logic [31:0]          event_count;
    logic [31:0]          discard_count;
    logic [47:0]          sent_bytes;
    logic [TIME_BITS-1:0] sample_time;

    modport source (output valid, output max_size, output min_size, output avg_size,
                    output event_count, output discard_count, output sent_bytes,
                    output sample_time, input ready);
    modport sink   (input valid, input max_size, input min_size, input avg_size,
                    input event_count, input discard_count, input sent_bytes,
                    input sample_time, output ready);
endinterface

FILE: src/qosm_div.sv
// bit-serial restoring divider for the average
module qosm_div
    import qosm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [AVG_W-1:0]    i_dividend,
    input  logic [PERIOD_W-1:0] i_divisor,
    output logic                o_done,
    output logic [AVG_W-1:0]    o_quotient
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [AVG_W-1:0]     r_quo;
    logic [PERIOD_W-1:0]  r_rem;
    logic [PERIOD_W-1:0]  r_dvs;

    logic [PERIOD_W:0]    w_shift;
    logic                 w_ge;
    logic [PERIOD_W:0]    w_diff;

    assign w_shift = {r_rem, r_quo[AVG_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});
    assign w_diff  = w_shift - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, msb first
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[AVG_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[PERIOD_W-1:0] : w_shift[PERIOD_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: src/qosm_ctrl.sv
// sequencer: intake, multiply steps, accumulate, divide, emit
module qosm_ctrl
    import qosm_pkg::*;
#(
    parameter int unsigned TIME_BITS = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int unsigned NCH = (TIME_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int unsigned CW  = (NCH > 1) ? $clog2(NCH) : 1;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_cnt        = '0;
                    n_state      = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(NCH - 1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (!i_status.sample_pend) begin
                    n_state = S_IDLE;
                end else if (i_status.use_div) begin
                    n_state = S_DSTART;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: src/qosm_dp.sv
// datapath: statistics state, interval multiply, accumulation and result register
module qosm_dp
    import qosm_pkg::*;
#(
    parameter int unsigned SIZE_BITS = 24,
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    input  logic                 i_opcode,
    input  logic [TIME_BITS-1:0] i_timestamp,
    input  logic [SIZE_BITS-1:0] i_queue_size,
    input  logic [DISC_W-1:0]    i_discards,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [SIZE_BITS-1:0] o_max_size,
    output logic [SIZE_BITS-1:0] o_min_size,
    output logic [AVG_W-1:0]     o_avg_size,
    output logic [CNT_W-1:0]     o_event_count,
    output logic [CNT_W-1:0]     o_discard_count,
    output logic [SENT_W-1:0]    o_sent_bytes,
    output logic [TIME_BITS-1:0] o_sample_time
);

    localparam int unsigned NCH = (TIME_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int unsigned DW  = NCH * CHUNK_W;
    localparam int unsigned PW  = SIZE_BITS + DW;
    localparam int unsigned AW  = (PW > AVG_W) ? PW : AVG_W;

    logic [PERIOD_W-1:0]  r_period;
    logic                 r_log;
    logic [TIME_BITS-1:0] r_last_time;
    logic                 r_have_last;
    logic [SIZE_BITS-1:0] r_last_size;
    logic [AVG_W-1:0]     r_wsum;
    logic [SIZE_BITS-1:0] r_max;
    logic [SIZE_BITS-1:0] r_min;
    logic [CNT_W-1:0]     r_evt;
    logic [CNT_W-1:0]     r_disc;
    logic [SENT_W-1:0]    r_sent;
    logic                 r_sample_pend;
    logic [TIME_BITS-1:0] r_time;
    logic [SIZE_BITS-1:0] r_mul_size;
    logic [DW-1:0]        r_dt;
    logic [AW-1:0]        r_prod;
    logic                 r_out_valid;

    logic                 w_close;
    logic                 w_fwd;
    logic [TIME_BITS-1:0] w_dt;
    logic [CNT_W:0]       w_evt_sum;
    logic [CNT_W:0]       w_disc_sum;
    logic [SIZE_BITS-1:0] w_drop;
    logic [SENT_W:0]      w_sent_sum;
    logic [SIZE_BITS+CHUNK_W-1:0] w_pp;
    logic                 w_ovf;
    logic [AVG_W-1:0]     w_prod64;
    logic [AVG_W:0]       w_wsum_sum;
    logic                 w_div_done;
    logic [AVG_W-1:0]     w_quo;

    assign w_close    = r_have_last && (i_timestamp != r_last_time);
    assign w_fwd      = r_have_last && (i_timestamp > r_last_time);
    assign w_dt       = w_fwd ? (i_timestamp - r_last_time) : '0;
    assign w_evt_sum  = {1'b0, r_evt} + (CNT_W+1)'(1);
    assign w_disc_sum = {1'b0, r_disc} + (CNT_W+1)'(i_discards);
    assign w_drop     = r_last_size - i_queue_size;
    assign w_sent_sum = {1'b0, r_sent} + (SENT_W+1)'(w_drop);

    assign w_pp       = r_mul_size * r_dt[DW-1 -: CHUNK_W];
    assign w_ovf      = |(r_prod >> AVG_W);
    assign w_prod64   = w_ovf ? '1 : r_prod[AVG_W-1:0];
    assign w_wsum_sum = {1'b0, r_wsum} + {1'b0, w_prod64};

    qosm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_wsum),
        .i_divisor  (r_period),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period      <= PERIOD_W'(1000);
            r_log         <= 1'b0;
            r_last_time   <= '0;
            r_have_last   <= 1'b0;
            r_last_size   <= '0;
            r_wsum        <= '0;
            r_max         <= '0;
            r_min         <= '0;
            r_evt         <= '0;
            r_disc        <= '0;
            r_sent        <= '0;
            r_sample_pend <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_SAMPLE_PERIOD:   r_period <= i_cfg_data;
                    CFG_LOG_EVERY_EVENT: r_log    <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (i_cmd.accept) begin
                // min and max see the size that was held up to now
                if (w_close) begin
                    if (r_last_size > r_max) r_max <= r_last_size;
                    if (r_last_size < r_min) r_min <= r_last_size;
                end
                r_last_time   <= i_timestamp;
                r_have_last   <= 1'b1;
                r_sample_pend <= (i_opcode == OP_SAMPLE) || r_log;
                if (i_opcode == OP_REPORT) begin
                    r_evt  <= w_evt_sum[CNT_W] ? '1 : w_evt_sum[CNT_W-1:0];
                    r_disc <= w_disc_sum[CNT_W] ? '1 : w_disc_sum[CNT_W-1:0];
                    if (i_queue_size < r_last_size) begin
                        r_sent <= w_sent_sum[SENT_W] ? '1 : w_sent_sum[SENT_W-1:0];
                    end
                    r_last_size <= i_queue_size;
                end
            end

            if (i_cmd.acc) begin
                r_wsum <= w_wsum_sum[AVG_W] ? '1 : w_wsum_sum[AVG_W-1:0];
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_evt       <= '0;
                r_disc      <= '0;
                r_sent      <= '0;
                r_wsum      <= '0;
                r_max       <= r_last_size;
                r_min       <= r_last_size;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // interval product, most significant chunk of the time step first
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_time     <= i_timestamp;
            r_mul_size <= r_last_size;
            r_dt       <= DW'(w_dt);
            r_prod     <= '0;
        end else if (i_cmd.mul_step) begin
            r_dt   <= r_dt << CHUNK_W;
            r_prod <= (r_prod << CHUNK_W) + AW'(w_pp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_max_size      <= r_max;
            o_min_size      <= r_min;
            o_avg_size      <= o_status.use_div ? w_quo : r_wsum;
            o_event_count   <= r_evt;
            o_discard_count <= r_disc;
            o_sent_bytes    <= r_sent;
            o_sample_time   <= r_time;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status.sample_pend = r_sample_pend;
    assign o_status.use_div     = !r_log && (r_period != '0);
    assign o_status.div_done    = w_div_done;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

endmodule

FILE: src/queue_occupancy_stats_monitor_core.sv
// top level of the queue occupancy statistics monitor
// report item: intake, one multiply step per 16-bit chunk of TIME_BITS (rounded up), then accumulate
// sample item: the report steps, then divider start, the quotient bits msb first and done when dividing,
//   then emit once the output is free; log mode or a zero period skips the divide and emits the sum
// a result is registered and the next item is taken while it waits to be read
// reset (i_rst_n low, synchronous) clears all statistics, sample_period 1000, log_every_event 0
module queue_occupancy_stats_monitor_core
    import qosm_pkg::*;
#(
    parameter int unsigned SIZE_BITS = 24,
    parameter int unsigned TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PERIOD_W-1:0]  i_cfg_data,
    qosm_in_if.sink              i_in,
    qosm_out_if.source           o_out
);

    // command and status between sequencer and datapath
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    // sequencer: one item at a time, ready only when idle
    qosm_ctrl #(
        .TIME_BITS (TIME_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    assign i_in.ready = w_in_ready;

    // datapath: statistics state, multiply, divider and the result register
    qosm_dp #(
        .SIZE_BITS (SIZE_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_opcode        (i_in.opcode),
        .i_timestamp     (i_in.timestamp),
        .i_queue_size    (i_in.queue_size),
        .i_discards      (i_in.discards),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_max_size      (o_out.max_size),
        .o_min_size      (o_out.min_size),
        .o_avg_size      (o_out.avg_size),
        .o_event_count   (o_out.event_count),
        .o_discard_count (o_out.discard_count),
        .o_sent_bytes    (o_out.sent_bytes),
        .o_sample_time   (o_out.sample_time)
    );

endmodule
